[src/mhb_pkg.sv]
// mhb_pkg: shared constants, payload types and control structs of the max heap builder.
// No dependencies; every other file except mhb_ram refers to it by scoped names.
package mhb_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    // child index of any stored node, up to 2*DEPTH
    localparam int CH_W  = IDX_W + 2;
    localparam int VAL_W = 32;

    typedef struct packed {
        logic signed [VAL_W-1:0] in_value;
        logic                    in_last;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_value;
        logic                    out_last;
        logic                    out_overflow;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // store the accepted item or flag a drop
        logic start_sift;  // k = n/2 - 1, node = k
        logic fetch;       // read store at node
        logic latch_cur;   // capture the value being sifted
        logic rd_left;     // read left child
        logic cmp_left;    // pick between sifted value and left child
        logic rd_right;    // read right child
        logic cmp_right;   // pick between best so far and right child
        logic place;       // write sifted value at node
        logic move;        // write winning child at node, descend
        logic next_node;   // k = k - 1, node = k - 1
        logic emit_start;  // emit index = 0
        logic emit_rd;     // read store at emit index
        logic emit_load;   // fill output register, advance emit index
        logic clear;       // empty the store
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sift_none;    // array after this item has no internal node
        logic left_ok;      // left child of node lies inside the array
        logic right_ok;     // right child of node lies inside the array
        logic best_is_node; // no child beat the sifted value
        logic k_zero;       // root sift is the current one
        logic emit_last;    // emit index is the last element
        logic out_free;     // output register can take an item this cycle
    } status_t;

endpackage

[src/mhb_ram.sv]
// mhb_ram: generic one-write, one-read memory with registered read data.
// No dependencies.
module mhb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/mhb_ctrl.sv]
// mhb_ctrl: state machine sequencing load, sift down and emit of the heap builder.
// Depends on mhb_pkg.
module mhb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    input  mhb_pkg::status_t status,
    output mhb_pkg::cmd_t    cmd
);

    typedef enum logic [8:0] {
        S_LOAD    = 9'b000000001,
        S_FETCH   = 9'b000000010,
        S_LATCH   = 9'b000000100,
        S_CHILD   = 9'b000001000,
        S_LEFT    = 9'b000010000,
        S_RIGHT   = 9'b000100000,
        S_CHK     = 9'b001000000,
        S_EMIT_RD = 9'b010000000,
        S_EMIT_LD = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_LOAD);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        if (status.sift_none)
                        begin
                            cmd.emit_start = 1'b1;
                            state_next     = S_EMIT_RD;
                        end
                        else
                        begin
                            cmd.start_sift = 1'b1;
                            state_next     = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_LATCH;
            end
            S_LATCH:
            begin
                cmd.latch_cur = 1'b1;
                state_next    = S_CHILD;
            end
            S_CHILD:
            begin
                if (status.left_ok)
                begin
                    cmd.rd_left = 1'b1;
                    state_next  = S_LEFT;
                end
                else
                begin
                    cmd.place = 1'b1;
                    if (status.k_zero)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = S_EMIT_RD;
                    end
                    else
                    begin
                        cmd.next_node = 1'b1;
                        state_next    = S_FETCH;
                    end
                end
            end
            S_LEFT:
            begin
                cmd.cmp_left = 1'b1;
                if (status.right_ok)
                begin
                    cmd.rd_right = 1'b1;
                    state_next   = S_RIGHT;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_RIGHT:
            begin
                cmd.cmp_right = 1'b1;
                state_next    = S_CHK;
            end
            S_CHK:
            begin
                if (status.best_is_node)
                begin
                    cmd.place = 1'b1;
                    if (status.k_zero)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = S_EMIT_RD;
                    end
                    else
                    begin
                        cmd.next_node = 1'b1;
                        state_next    = S_FETCH;
                    end
                end
                else
                begin
                    cmd.move   = 1'b1;
                    state_next = S_CHILD;
                end
            end
            S_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (status.emit_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

[src/mhb_dp.sv]
// mhb_dp: element store, sift registers, counters and output register of the heap builder.
// Depends on mhb_pkg and mhb_ram.
module mhb_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  mhb_pkg::cmd_t      cmd,
    output mhb_pkg::status_t   status,
    input  mhb_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mhb_pkg::out_item_t out_data
);

    logic [mhb_pkg::CNT_W-1:0]        count_reg;
    logic                             dropped_reg;
    logic [mhb_pkg::IDX_W-1:0]        k_reg;
    logic [mhb_pkg::IDX_W-1:0]        node_reg;
    logic [mhb_pkg::IDX_W-1:0]        emit_idx_reg;
    logic [mhb_pkg::IDX_W-1:0]        best_idx_reg;
    logic signed [mhb_pkg::VAL_W-1:0] cur_reg;
    logic signed [mhb_pkg::VAL_W-1:0] best_val_reg;
    logic                             out_valid_reg;
    mhb_pkg::out_item_t               out_data_reg;

    logic                             full;
    logic [mhb_pkg::CNT_W-1:0]        n_after;
    logic [mhb_pkg::CNT_W-1:0]        k_start;
    logic [mhb_pkg::CH_W-1:0]         left;
    logic [mhb_pkg::CH_W-1:0]         right;
    logic [mhb_pkg::CH_W-1:0]         n_ext;
    logic signed [mhb_pkg::VAL_W-1:0] rd_val;
    logic [mhb_pkg::VAL_W-1:0]        rdata;

    logic                             we;
    logic [mhb_pkg::IDX_W-1:0]        waddr;
    logic [mhb_pkg::VAL_W-1:0]        wdata;
    logic                             re;
    logic [mhb_pkg::IDX_W-1:0]        raddr;

    assign full    = (count_reg == mhb_pkg::CNT_W'(mhb_pkg::DEPTH));
    assign n_after = full ? count_reg : count_reg + 1'b1;
    assign k_start = (n_after >> 1) - 1'b1;
    assign left    = {1'b0, node_reg, 1'b1};
    assign right   = left + 1'b1;
    assign n_ext   = mhb_pkg::CH_W'(count_reg);
    assign rd_val  = $signed(rdata);

    assign status.sift_none    = ((n_after >> 1) == '0);
    assign status.left_ok      = (left < n_ext);
    assign status.right_ok     = (right < n_ext);
    assign status.best_is_node = (best_idx_reg == node_reg);
    assign status.k_zero       = (k_reg == '0);
    assign status.emit_last    = ((mhb_pkg::CNT_W'(emit_idx_reg) + 1'b1) == count_reg);
    assign status.out_free     = !out_valid_reg || out_ready;

    // write port: load, final placement of the sifted value, or a child moving up
    always_comb
    begin
        we    = 1'b0;
        waddr = node_reg;
        wdata = cur_reg;
        if (cmd.load)
        begin
            we    = !full;
            waddr = count_reg[mhb_pkg::IDX_W-1:0];
            wdata = in_data.in_value;
        end
        else if (cmd.move)
        begin
            we    = 1'b1;
            wdata = best_val_reg;
        end
        else if (cmd.place)
        begin
            we = 1'b1;
        end
    end

    // read port
    always_comb
    begin
        re    = cmd.fetch || cmd.rd_left || cmd.rd_right || cmd.emit_rd;
        raddr = node_reg;
        if (cmd.rd_left)
        begin
            raddr = left[mhb_pkg::IDX_W-1:0];
        end
        else if (cmd.rd_right)
        begin
            raddr = right[mhb_pkg::IDX_W-1:0];
        end
        else if (cmd.emit_rd)
        begin
            raddr = emit_idx_reg;
        end
    end

    mhb_ram #(
        .WIDTH (mhb_pkg::VAL_W),
        .DEPTH (mhb_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                count_reg <= n_after;
                if (full)
                begin
                    dropped_reg <= 1'b1;
                end
            end
            if (cmd.clear)
            begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end
            if (cmd.emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sift and emit payload
    always_ff @(posedge clk)
    begin
        if (cmd.start_sift)
        begin
            k_reg    <= k_start[mhb_pkg::IDX_W-1:0];
            node_reg <= k_start[mhb_pkg::IDX_W-1:0];
        end
        if (cmd.next_node)
        begin
            k_reg    <= k_reg - 1'b1;
            node_reg <= k_reg - 1'b1;
        end
        if (cmd.move)
        begin
            node_reg <= best_idx_reg;
        end
        if (cmd.latch_cur)
        begin
            cur_reg <= rd_val;
        end
        if (cmd.cmp_left)
        begin
            if (rd_val > cur_reg)
            begin
                best_val_reg <= rd_val;
                best_idx_reg <= left[mhb_pkg::IDX_W-1:0];
            end
            else
            begin
                best_val_reg <= cur_reg;
                best_idx_reg <= node_reg;
            end
        end
        if (cmd.cmp_right && (rd_val > best_val_reg))
        begin
            best_val_reg <= rd_val;
            best_idx_reg <= right[mhb_pkg::IDX_W-1:0];
        end
        if (cmd.emit_start)
        begin
            emit_idx_reg <= '0;
        end
        if (cmd.emit_load)
        begin
            emit_idx_reg              <= emit_idx_reg + 1'b1;
            out_data_reg.out_value    <= rd_val;
            out_data_reg.out_last     <= status.emit_last;
            out_data_reg.out_overflow <= dropped_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[src/max_heap_builder.sv]
// max_heap_builder: top level, bottom-up max heap construction over a 64-entry store.
// Depends on mhb_pkg, mhb_ctrl, mhb_dp (which holds mhb_ram).
//
//   channel | signals                      | payload type
//   --------+------------------------------+---------------------
//   input   | in_valid, in_ready, in_data  | mhb_pkg::in_item_t
//   output  | out_valid, out_ready, out_data | mhb_pkg::out_item_t
//
// Loading takes one item per cycle; the item with in_last starts the build. Each
// internal node from n/2-1 down to 0 is fetched and latched, then sifted one level
// at a time over the single read port: compare the left child, then the right one
// if present, then move the winner up or place the value. Emit reads each result
// through the registered read and loads it when the output register is free.
// After reset the block is empty and takes items at once. A stalled output holds
// its result in the output register; the last may wait there while the next array loads.
module max_heap_builder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mhb_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mhb_pkg::out_item_t out_data
);

    mhb_pkg::cmd_t    cmd;
    mhb_pkg::status_t status;

    // sequence load, sift and emit
    mhb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_data.in_last),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // hold the store, the sift registers and the output register
    mhb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[tb/mhb_heap_checker.sv]
// mhb_heap_checker: watches both channels of max_heap_builder, rebuilds each heap
// from the accepted items and compares every emitted item against it.
// Depends on mhb_pkg for the payload types and the store depth.
module mhb_heap_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  mhb_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  mhb_pkg::out_item_t out_data,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [mhb_pkg::VAL_W-1:0] load_store [mhb_pkg::DEPTH];
    int                               load_count;
    bit                               load_dropped;
    mhb_pkg::out_item_t               heap_q [$];
    mhb_pkg::out_item_t               want;
    int                               mismatch_total = 0;
    int                               result_idx = 0;

    assign fail_count = mismatch_total;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH item %0d: %s", $time, result_idx, msg);
        mismatch_total++;
    endtask

    // Walk one node down; the larger child wins, ties keep the parent.
    function automatic void sift_node(input int start, input int n);
        int node;
        int best;
        bit done;
        logic signed [mhb_pkg::VAL_W-1:0] tmp;
        node = start;
        done = 1'b0;
        while (!done)
        begin
            best = node;
            if (2 * node + 1 < n && load_store[2 * node + 1] > load_store[best])
                best = 2 * node + 1;
            if (2 * node + 2 < n && load_store[2 * node + 2] > load_store[best])
                best = 2 * node + 2;
            if (best == node)
                done = 1'b1;
            else
            begin
                tmp = load_store[node];
                load_store[node] = load_store[best];
                load_store[best] = tmp;
                node = best;
            end
        end
    endfunction

    // Heapify the loaded array, queue it in array order, then empty the store.
    function automatic void build_heap_items();
        mhb_pkg::out_item_t item;
        for (int k = load_count / 2; k > 0; k--)
            sift_node(k - 1, load_count);
        for (int k = 0; k < load_count; k++)
        begin
            item.out_value    = load_store[k];
            item.out_last     = (k == load_count - 1);
            item.out_overflow = load_dropped;
            heap_q.push_back(item);
        end
        load_count   = 0;
        load_dropped = 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count   = 0;
            load_dropped = 1'b0;
            heap_q.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (heap_q.size() == 0)
                    report_mismatch($sformatf("unexpected result value=%0d last=%b ovf=%b",
                        out_data.out_value, out_data.out_last, out_data.out_overflow));
                else
                begin
                    want = heap_q.pop_front();
                    if (out_data.out_value !== want.out_value)
                        report_mismatch($sformatf("out_value got %0d want %0d",
                            out_data.out_value, want.out_value));
                    if (out_data.out_last !== want.out_last)
                        report_mismatch($sformatf("out_last got %b want %b",
                            out_data.out_last, want.out_last));
                    if (out_data.out_overflow !== want.out_overflow)
                        report_mismatch($sformatf("out_overflow got %b want %b",
                            out_data.out_overflow, want.out_overflow));
                end
                result_idx++;
            end
            if (in_valid && in_ready)
            begin
                if (load_count < mhb_pkg::DEPTH)
                begin
                    load_store[load_count] = in_data.in_value;
                    load_count++;
                end
                else
                    load_dropped = 1'b1;
                if (in_data.in_last)
                    build_heap_items();
            end
            pending <= heap_q.size();
        end
    end

endmodule

[tb/tb_max_heap_builder.sv]
// tb_max_heap_builder: stimulus and verdict for max_heap_builder.
// Depends on mhb_pkg, the block under test and mhb_heap_checker, which does all checking.
module tb_max_heap_builder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT     = 29;   // chance per cycle that a side idles
    localparam int RANDOM_ITEMS = 345;  // stop opening new arrays past this count
    localparam int DRAIN_CYCLES = 40;   // settle time once nothing is expected

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    mhb_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    mhb_pkg::out_item_t out_data;

    int fail_count;
    int pending;
    int sent_items;
    // while set, neither side idles: back-to-back traffic on both channels
    bit steady = 1'b0;

    // Directed arrays, last mark closes each one:
    //   single element at each extreme, two elements in both orders,
    //   all equal values (ties keep the parent), equal children,
    //   ascending run (every node sifts to the bottom), alternating bit patterns.
    logic [31:0] dir_vals [25] = '{
        32'h8000_0000,
        32'h7FFF_FFFF,
        32'h8000_0000, 32'h7FFF_FFFF,
        32'h7FFF_FFFF, 32'h8000_0000,
        32'd5, 32'd5, 32'd5,
        32'd1, 32'd7, 32'd7, 32'd3,
        32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7,
        32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'd0, 32'd1
    };
    bit dir_last [25] = '{
        1, 1, 0, 1, 0, 1, 0, 0, 1, 0, 0, 0, 1,
        0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1
    };

    max_heap_builder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    mhb_heap_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop, far past the slowest legal run.
    initial
    begin
        #3ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: drop ready at random, except during the steady stretch.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Offer one item; hold it until the handshake. Random idle cycles go first
    // so gaps land on every phase of loading, sifting and emitting.
    task automatic send_item(input logic [31:0] value, input bit last);
        mhb_pkg::in_item_t item;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        item.in_value = value;
        item.in_last  = last;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
    endtask

    // Mix extremes and a narrow band (many ties) with full-range words.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3, 4: return $unsigned($signed($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_array(input int size);
        for (int i = 0; i < size; i++)
            send_item(pick_value(), i == size - 1);
    endtask

    initial
    begin
        int size;
        int arr;
        sent_items = 0;

        // Hold reset, then release it on a rising edge.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 25; i++)
            send_item(dir_vals[i], dir_last[i]);

        // Random arrays. The first overruns the store (the last-marked item is
        // dropped too), the second fills it exactly; after that mostly short
        // arrays, with a rare large one that may or may not overflow.
        arr = 0;
        while (sent_items < 25 + RANDOM_ITEMS)
        begin
            steady = (arr >= 10 && arr < 16);
            if (arr == 0)
                size = mhb_pkg::DEPTH + 6;
            else if (arr == 1)
                size = mhb_pkg::DEPTH;
            else if ($urandom_range(0, 19) == 0)
                size = $urandom_range(mhb_pkg::DEPTH - 4, mhb_pkg::DEPTH + 2);
            else
                size = $urandom_range(1, 12);
            send_array(size);
            arr++;
        end
        steady = 1'b0;

        // Release the channel, let the checker see the final item, then drain.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
